@@ rtl/sobel_gradient_magnitude_top_defines.svh @@
// Assertion macros shared by the Sobel gradient magnitude RTL.
// Depends on nothing; take in with `include by bare file name.
`ifndef SOBEL_GRADIENT_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define SGM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sgm_pkg.sv @@
// Shared constants, register indexes and interface structs of the Sobel block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

    // Frame geometry
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int MinDim     = 3;
    localparam int PixelBits  = 8;
    localparam int ColBits    = $clog2(MaxWidth);
    localparam int RowBits    = $clog2(MaxHeight);
    localparam int WidthBits  = ColBits + 1;
    localparam int HeightBits = RowBits + 1;

    // Gradient and root arithmetic
    localparam int GradBits = PixelBits + 2;
    localparam int SumBits  = 2 * GradBits + 1;
    localparam int RootBits = PixelBits;

    // Queue between front and back
    localparam int QDepth     = 2;
    localparam int QPtrBits   = $clog2(QDepth);
    localparam int QCountBits = $clog2(QDepth + 1);

    // Configuration registers
    localparam int RegIdxBits = 1;
    localparam int AddrBits   = RegIdxBits + 2;
    localparam int DataBits   = 32;
    localparam logic [RegIdxBits-1:0] REG_WIDTH  = 1'd0;
    localparam logic [RegIdxBits-1:0] REG_HEIGHT = 1'd1;
    localparam logic [WidthBits-1:0]  WIDTH_RESET  = WidthBits'(640);
    localparam logic [HeightBits-1:0] HEIGHT_RESET = HeightBits'(480);

    // One gradient pair waiting for its root
    typedef struct packed {
        logic [GradBits-1:0] ax;
        logic [GradBits-1:0] ay;
        logic [RowBits-1:0]  row;
        logic [ColBits-1:0]  col;
        logic                last;
    } t_grad_item;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Frame geometry in use, already clamped, and the restart strobe
    typedef struct packed {
        logic [WidthBits-1:0]  width;
        logic [HeightBits-1:0] height;
        logic                  restart;
    } t_frame_cfg;

endpackage

`default_nettype wire

@@ rtl/sgm_front.sv @@
// Front end: pixel intake, line stores, 3x3 window and Sobel gradients.
// Depends on sgm_pkg; feeds sgm_queue.
`timescale 1ns / 1ps
`default_nettype none

module sgm_front import sgm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_frame_cfg           i_cfg,
    input  logic                 i_pixel_valid,
    output logic                 o_pixel_ready,
    input  logic [PixelBits-1:0] i_pixel,
    input  t_q_status            i_q_status,
    output logic                 o_push,
    output t_grad_item           o_item
);

    // Line stores, read at intake, written when the beat leaves
    logic [PixelBits-1:0] r_upper  [0:MaxWidth-1];
    logic [PixelBits-1:0] r_middle [0:MaxWidth-1];

    logic [ColBits-1:0]   r_col;
    logic [RowBits-1:0]   r_row;
    logic                 r_valid;
    logic                 r_produce;
    logic                 r_last;
    logic [PixelBits-1:0] r_px;
    logic [PixelBits-1:0] r_top;
    logic [PixelBits-1:0] r_mid;
    logic [ColBits-1:0]   r_c;
    logic [RowBits-1:0]   r_r;
    logic [PixelBits-1:0] r_win [0:5];

    logic [ColBits-1:0]    c_eff;
    logic [RowBits-1:0]    row_eff;
    logic [WidthBits-1:0]  col_plus;
    logic [HeightBits-1:0] row_plus;
    logic                  col_wrap;
    logic                  row_wrap;
    logic [ColBits-1:0]    n_col;
    logic [RowBits-1:0]    n_row;
    logic                  accept;
    logic                  fire;
    logic [GradBits-1:0]   pos_x;
    logic [GradBits-1:0]   neg_x;
    logic [GradBits-1:0]   pos_y;
    logic [GradBits-1:0]   neg_y;

    function automatic logic [GradBits-1:0] abs_diff(input logic [GradBits-1:0] a,
                                                     input logic [GradBits-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Clamp counters into the frame and work out the next position
    always_comb begin
        if ({1'b0, r_col} >= i_cfg.width) begin
            c_eff = ColBits'(i_cfg.width - WidthBits'(1));
        end else begin
            c_eff = r_col;
        end
        if ({1'b0, r_row} >= i_cfg.height) begin
            row_eff = RowBits'(i_cfg.height - HeightBits'(1));
        end else begin
            row_eff = r_row;
        end
        col_plus = {1'b0, c_eff} + WidthBits'(1);
        row_plus = {1'b0, row_eff} + HeightBits'(1);
        col_wrap = col_plus >= i_cfg.width;
        row_wrap = row_plus >= i_cfg.height;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_plus[RowBits-1:0];
        end else begin
            n_col = col_plus[ColBits-1:0];
            n_row = row_eff;
        end
    end

    // Handshake: a held beat leaves when it needs no queue slot or one is free
    assign fire          = r_valid && (!r_produce || !i_q_status.full);
    assign o_pixel_ready = !r_valid || fire;
    assign accept        = i_pixel_valid && o_pixel_ready;
    assign o_push        = fire && r_produce;

    // Kernel taps split into positive and negative halves
    always_comb begin
        pos_x = GradBits'(r_top) + {1'b0, r_mid, 1'b0} + GradBits'(r_px);
        neg_x = GradBits'(r_win[0]) + {1'b0, r_win[1], 1'b0} + GradBits'(r_win[2]);
        pos_y = GradBits'(r_win[2]) + {1'b0, r_win[5], 1'b0} + GradBits'(r_px);
        neg_y = GradBits'(r_win[0]) + {1'b0, r_win[3], 1'b0} + GradBits'(r_top);
    end

    always_comb begin
        o_item.ax   = abs_diff(pos_x, neg_x);
        o_item.ay   = abs_diff(pos_y, neg_y);
        o_item.row  = r_r - RowBits'(1);
        o_item.col  = r_c - ColBits'(1);
        o_item.last = r_last;
    end

    // Advance position counters and hold the beat flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg.restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (fire) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Shift the window one column as the beat leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_px;
        end
    end

    // Capture the beat payload at intake
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px      <= i_pixel;
            r_c       <= c_eff;
            r_r       <= row_eff;
            r_produce <= (row_eff >= RowBits'(2)) && (c_eff >= ColBits'(2));
            r_last    <= col_wrap && row_wrap;
        end
    end

    // Line store access: read at intake, push rows down as the beat leaves
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top <= r_upper[c_eff];
            r_mid <= r_middle[c_eff];
        end
        if (fire) begin
            r_upper[r_c]  <= r_mid;
            r_middle[r_c] <= r_px;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sgm_queue.sv @@
// Short register queue of gradient pairs between front and back end.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgm_queue import sgm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_grad_item i_item,
    input  logic       i_pop,
    output t_grad_item o_head,
    output t_q_status  o_status
);

    t_grad_item            r_mem [0:QDepth-1];
    logic [QPtrBits-1:0]   r_wr;
    logic [QPtrBits-1:0]   r_rd;
    logic [QCountBits-1:0] r_count;

    function automatic logic [QPtrBits-1:0] ptr_next(input logic [QPtrBits-1:0] p);
        ptr_next = (p == QPtrBits'(QDepth - 1)) ? '0 : p + QPtrBits'(1);
    endfunction

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = r_count == QCountBits'(QDepth);
    assign o_status.empty = r_count == '0;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCountBits'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCountBits'(1);
            end
        end
    end

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sgm_back.sv @@
// Back end: squares the gradients, takes the saturated integer root bit by bit
// and holds the result beat. Depends on sgm_pkg; fed by sgm_queue.
`timescale 1ns / 1ps
`default_nettype none

module sgm_back import sgm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_status           i_q_status,
    input  t_grad_item          i_head,
    output logic                o_pop,
    output logic                o_result_valid,
    input  logic                i_result_ready,
    output logic [RootBits-1:0] o_magnitude,
    output logic [RowBits-1:0]  o_center_row,
    output logic [ColBits-1:0]  o_center_col,
    output logic                o_last_of_frame
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SQUARE = 2'd1;
    localparam logic [1:0] S_ROOT   = 2'd2;
    localparam logic [1:0] S_HOLD   = 2'd3;

    logic [1:0]            r_state;
    logic                  r_out_valid;
    t_grad_item            r_item;
    logic [SumBits-1:0]    r_sum;
    logic [RootBits-1:0]   r_root;
    logic [RootBits-1:0]   r_bit;
    logic [RootBits-1:0]   r_mag;
    logic [RowBits-1:0]    r_out_row;
    logic [ColBits-1:0]    r_out_col;
    logic                  r_out_last;

    logic [2*GradBits-1:0] sq_x;
    logic [2*GradBits-1:0] sq_y;
    logic [RootBits-1:0]   trial;
    logic [2*RootBits-1:0] trial_sq;
    logic                  sum_high;
    logic                  slot_free;

    assign sq_x      = r_item.ax * r_item.ax;
    assign sq_y      = r_item.ay * r_item.ay;
    assign trial     = r_root | r_bit;
    assign trial_sq  = trial * trial;
    assign sum_high  = |r_sum[SumBits-1:2*RootBits];
    assign slot_free = !r_out_valid || i_result_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_q_status.empty;

    assign o_result_valid  = r_out_valid;
    assign o_magnitude     = r_mag;
    assign o_center_row    = r_out_row;
    assign o_center_col    = r_out_col;
    assign o_last_of_frame = r_out_last;

    // Sequence one item through square, root and hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sum_high || r_bit[0]) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (r_state == S_HOLD && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: load, square, one root bit a cycle, output register
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_item <= i_head;
                end
            end
            S_SQUARE: begin
                r_sum  <= SumBits'(sq_x) + SumBits'(sq_y);
                r_root <= '0;
                r_bit  <= {1'b1, {(RootBits-1){1'b0}}};
            end
            S_ROOT: begin
                if (sum_high) begin
                    r_root <= '1;
                end else if (trial_sq <= r_sum[2*RootBits-1:0]) begin
                    r_root <= trial;
                end
                r_bit <= r_bit >> 1;
            end
            S_HOLD: begin
                if (slot_free) begin
                    r_mag      <= r_root;
                    r_out_row  <= r_item.row;
                    r_out_col  <= r_item.col;
                    r_out_last <= r_item.last;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sobel_gradient_magnitude_top.sv @@
// Sobel gradient magnitude over a raster stream of 8-bit grey pixels (top
// level; uses sgm_pkg, sgm_front, sgm_queue, sgm_back and the assertion
// header). Pixels go in one beat each in raster order; the front end takes one
// pixel per clock unless an interior pixel waits for a queue slot, keeps two
// line stores and a 3x3 window, and forms |gx| and |gy| for each interior
// centre. Border centres give no result. The back end turns each pair into
// floor(sqrt(gx^2+gy^2)), saturated at 255, with the centre's row, column and
// a last-of-frame mark. It steps each interior result through pop, square,
// eight root steps and hand-off, and its root unit resolves one result bit
// per cycle; a sum of squares of 65536 or more saturates at the first root
// step. It pops a new pair only when done with the last; a two-entry queue
// lets the front run ahead. Registers: width at 0x0 (11 bits, clamped to
// 3..1024), height at 0x4 (13 bits, clamped to 3..4096); a write restarts
// the frame. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sobel_gradient_magnitude_top_defines.svh"

module sobel_gradient_magnitude_top import sgm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrBits-1:0]  paddr,
    input  logic [DataBits-1:0]  pwdata,
    output logic [DataBits-1:0]  prdata,
    output logic                 pready,
    input  logic                 i_pixel_valid,
    output logic                 o_pixel_ready,
    input  logic [PixelBits-1:0] i_pixel,
    output logic                 o_result_valid,
    input  logic                 i_result_ready,
    output logic [RootBits-1:0]  o_magnitude,
    output logic [RowBits-1:0]   o_center_row,
    output logic [ColBits-1:0]   o_center_col,
    output logic                 o_last_of_frame
);

    logic [WidthBits-1:0]  r_width;
    logic [HeightBits-1:0] r_height;

    logic                  cfg_write;
    logic [RegIdxBits-1:0] reg_idx;
    t_frame_cfg            frame_cfg;
    t_grad_item            front_item;
    t_grad_item            q_head;
    t_q_status             q_status;
    logic                  q_push;
    logic                  q_pop;

    // Register port decode
    assign pready    = 1'b1;
    assign reg_idx   = paddr[AddrBits-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = DataBits'(r_width);
            REG_HEIGHT: prdata = DataBits'(r_height);
        endcase
    end

    // Hold the frame geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[WidthBits-1:0];
                REG_HEIGHT: r_height <= pwdata[HeightBits-1:0];
            endcase
        end
    end

    // Clamp geometry into the supported range
    always_comb begin
        if (r_width < WidthBits'(MinDim)) begin
            frame_cfg.width = WidthBits'(MinDim);
        end else if (r_width > WidthBits'(MaxWidth)) begin
            frame_cfg.width = WidthBits'(MaxWidth);
        end else begin
            frame_cfg.width = r_width;
        end
        if (r_height < HeightBits'(MinDim)) begin
            frame_cfg.height = HeightBits'(MinDim);
        end else if (r_height > HeightBits'(MaxHeight)) begin
            frame_cfg.height = HeightBits'(MaxHeight);
        end else begin
            frame_cfg.height = r_height;
        end
        frame_cfg.restart = cfg_write;
    end

    sgm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (frame_cfg),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .i_q_status    (q_status),
        .o_push        (q_push),
        .o_item        (front_item)
    );

    sgm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    sgm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_result_valid  (o_result_valid),
        .i_result_ready  (i_result_ready),
        .o_magnitude     (o_magnitude),
        .o_center_row    (o_center_row),
        .o_center_col    (o_center_col),
        .o_last_of_frame (o_last_of_frame)
    );

    // Queue discipline between front and back
    `SGM_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_status.full, "push into full queue")
    `SGM_ASSERT_IMPLY(a_no_pop_when_empty, i_clk, i_rst_n, q_pop, !q_status.empty, "pop from empty queue")
    `SGM_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push && !q_pop, !q_status.empty, "pushed entry lost")

endmodule

`default_nettype wire
